>>> rtl/scla_pkg.sv
`default_nettype none
package scla_pkg;

	localparam int LINE_MAX_DEF = 64;
	localparam int BYTE_W       = 8;
	localparam int CHAR_IDX_W   = 6;

	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_ERR  = 1'b1;

	typedef struct packed {
		logic wr;
		logic set_ovf;
		logic clr;
		logic rd_en;
		logic rd_inc;
		logic ld_char;
		logic ld_err;
	} scla_cmd_t;

	typedef struct packed {
		logic is_term;
		logic is_print;
		logic full;
		logic ovf;
		logic empty;
		logic last;
		logic slot_free;
	} scla_sts_t;

endpackage
`default_nettype wire

>>> rtl/scla_dp.sv
`default_nettype none
module scla_dp import scla_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [BYTE_W-1:0]     in_byte,
	input  wire logic                  out_stall,
	input  wire scla_cmd_t             cmd,
	output scla_sts_t                  sts,
	output logic                       out_valid,
	output logic                       out_kind,
	output logic [BYTE_W-1:0]          line_char,
	output logic [CHAR_IDX_W-1:0]      char_index,
	output logic                       last_flag
);

	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
	localparam int LW = $clog2(LINE_MAX + 1);

	logic [BYTE_W-1:0]     mem [LINE_MAX];
	logic [BYTE_W-1:0]     rdata_q;
	logic [LW-1:0]         len_q;
	logic                  ovf_q;
	logic [AW-1:0]         rd_q;
	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [BYTE_W-1:0]     out_char_q;
	logic [CHAR_IDX_W-1:0] out_idx_q;
	logic                  out_last_q;
	logic [LW-1:0]         rd_next;

	assign rd_next = LW'(rd_q) + LW'(1);

	always_comb begin
		sts.is_term   = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
		sts.is_print  = (in_byte >= PRINT_LO) && (in_byte <= PRINT_HI);
		sts.full      = (len_q == LW'(LINE_MAX));
		sts.ovf       = ovf_q;
		sts.empty     = (len_q == '0);
		sts.last      = (rd_next == len_q);
		sts.slot_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[len_q[AW-1:0]] <= in_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			rd_q  <= '0;
		end else begin
			if (cmd.clr) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				rd_q  <= '0;
			end else begin
				if (cmd.wr) begin
					len_q <= len_q + LW'(1);
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
				if (cmd.rd_inc) begin
					rd_q <= rd_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_char || cmd.ld_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_char) begin
			out_kind_q <= KIND_CHAR;
			out_char_q <= rdata_q;
			out_idx_q  <= CHAR_IDX_W'(rd_q);
			out_last_q <= sts.last;
		end else if (cmd.ld_err) begin
			out_kind_q <= KIND_ERR;
			out_char_q <= '0;
			out_idx_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign line_char  = out_char_q;
	assign char_index = out_idx_q;
	assign last_flag  = out_last_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_char || cmd.ld_err) |-> sts.slot_free)
		else $error("Result loaded over a pending transfer.");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(LINE_MAX))
		else $error("Line length beyond capacity.");
	a_wr_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !sts.full)
		else $error("Write into a full line store.");
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_ERR) |-> (out_char_q == '0 && out_last_q))
		else $error("Malformed line-too-long result.");
`endif

endmodule
`default_nettype wire

>>> rtl/scla_ctrl.sv
`default_nettype none
module scla_ctrl import scla_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire scla_sts_t sts,
	output scla_cmd_t      cmd,
	output logic           in_stall
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_ERR
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.is_term) begin
						cmd.clr = !sts.ovf && sts.empty;
					end else if (sts.is_print) begin
						cmd.wr      = !sts.full;
						cmd.set_ovf = sts.full;
					end
				end
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
			end
			S_LOAD: begin
				if (sts.slot_free) begin
					cmd.ld_char = 1'b1;
					cmd.clr     = sts.last;
					cmd.rd_inc  = !sts.last;
				end
			end
			S_ERR: begin
				if (sts.slot_free) begin
					cmd.ld_err = 1'b1;
					cmd.clr    = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && sts.is_term) begin
						if (sts.ovf) begin
							state_q <= S_ERR;
						end else if (!sts.empty) begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (sts.slot_free) begin
						state_q <= sts.last ? S_IDLE : S_FETCH;
					end
				end
				S_ERR: begin
					if (sts.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_char || cmd.ld_err || cmd.rd_en) |-> in_stall)
		else $error("Readout active while input transfers are taken.");
	a_fetch_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (state_q == S_LOAD))
		else $error("Store read not followed by a load state.");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ld_char && cmd.ld_err))
		else $error("Two result loads at once.");
`endif

endmodule
`default_nettype wire

>>> rtl/serial_command_line_assembler.sv
`default_nettype none
// Assembles received serial bytes into lines. Printable bytes are stored while the line has
// room and otherwise mark it as overflowed; other bytes except CR and LF are ignored. A CR or
// LF ends the line: an empty line gives nothing, an overflowed line gives one line-too-long
// result, and otherwise the stored characters come out in order with the last one marked.
// During readout in_stall stays high and each character passes through a read of the line
// store and then a load of the output register, which waits while out_stall holds the output
// register. A pending output transfer does not stop ordinary bytes from being taken.
module serial_command_line_assembler import scla_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [BYTE_W-1:0]     in_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       out_kind,
	output logic [BYTE_W-1:0]          line_char,
	output logic [CHAR_IDX_W-1:0]      char_index,
	output logic                       last_flag
);

	scla_cmd_t cmd;
	scla_sts_t sts;

	scla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	scla_dp #(
		.LINE_MAX (LINE_MAX)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_kind   (out_kind),
		.line_char  (line_char),
		.char_index (char_index),
		.last_flag  (last_flag)
	);

endmodule
`default_nettype wire

>>> sim/line_assembler_checker.sv
module line_assembler_checker import scla_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [BYTE_W-1:0]     in_byte,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic                  out_kind,
	input  wire logic [BYTE_W-1:0]     line_char,
	input  wire logic [CHAR_IDX_W-1:0] char_index,
	input  wire logic                  last_flag,
	output int                         mismatches,
	output int                         awaited,
	output int                         results_checked,
	output int                         lines_closed,
	output int                         long_lines
);

	typedef struct packed {
		logic                  kind;
		logic [BYTE_W-1:0]     ch;
		logic [CHAR_IDX_W-1:0] idx;
		logic                  last;
	} line_result_t;

	logic [BYTE_W-1:0] line_chars [LINE_MAX_DEF];
	int unsigned       char_count = 0;
	bit                too_long = 1'b0;
	line_result_t      expected_line [$];
	int                fail_total = 0;
	int                checked_total = 0;
	int                lines_total = 0;
	int                long_total = 0;

	// Advances the line state by one accepted byte and queues whatever a terminator releases.
	task automatic take_byte(input logic [BYTE_W-1:0] b);
		line_result_t r;
		if (b == CHAR_CR || b == CHAR_LF) begin
			if (too_long) begin
				r.kind = KIND_ERR;
				r.ch   = '0;
				r.idx  = '0;
				r.last = 1'b1;
				expected_line.push_back(r);
				long_total++;
			end else begin
				for (int k = 0; k < int'(char_count); k++) begin
					r.kind = KIND_CHAR;
					r.ch   = line_chars[k];
					r.idx  = CHAR_IDX_W'(k);
					r.last = (k + 1 == int'(char_count));
					expected_line.push_back(r);
				end
				if (char_count != 0)
					lines_total++;
			end
			char_count = 0;
			too_long   = 1'b0;
		end else if (b >= PRINT_LO && b <= PRINT_HI) begin
			if (char_count >= LINE_MAX_DEF) begin
				too_long = 1'b1;
			end else begin
				line_chars[char_count] = b;
				char_count++;
			end
		end
	endtask

	task automatic check_result();
		line_result_t want;
		if (expected_line.size() == 0) begin
			$error("unexpected result: out_kind %0d line_char %h char_index %0d last_flag %0d",
				out_kind, line_char, char_index, last_flag);
			fail_total++;
		end else begin
			want = expected_line.pop_front();
			checked_total++;
			if (out_kind !== want.kind) begin
				$error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
				fail_total++;
			end
			if (line_char !== want.ch) begin
				$error("line_char: expected %h, actual %h", want.ch, line_char);
				fail_total++;
			end
			if (char_index !== want.idx) begin
				$error("char_index: expected %0d, actual %0d", want.idx, char_index);
				fail_total++;
			end
			if (last_flag !== want.last) begin
				$error("last_flag: expected %0d, actual %0d", want.last, last_flag);
				fail_total++;
			end
		end
	endtask

	// A result accepted at the same edge as a terminator belongs to an earlier line, so
	// the output side is checked before the input side is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_line.delete();
			char_count = 0;
			too_long   = 1'b0;
			awaited <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				take_byte(in_byte);
			awaited         <= expected_line.size();
			mismatches      <= fail_total;
			results_checked <= checked_total;
			lines_closed    <= lines_total;
			long_lines      <= long_total;
		end
	end

endmodule

>>> sim/testbench.sv
module testbench;
	import scla_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * LINE_MAX_DEF + 40;
	localparam int PHASE_ITEMS  = 5;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [BYTE_W-1:0]     in_byte = '0;
	logic                  out_stall = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  out_kind;
	logic [BYTE_W-1:0]     line_char;
	logic [CHAR_IDX_W-1:0] char_index;
	logic                  last_flag;

	int mismatches;
	int awaited;
	int results_checked;
	int lines_closed;
	int long_lines;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int bytes_sent = 0;
	int cycle_count = 0;

	logic [BYTE_W-1:0] opening_bytes [21];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	serial_command_line_assembler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.line_char  (line_char),
		.char_index (char_index),
		.last_flag  (last_flag)
	);

	line_assembler_checker line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_kind        (out_kind),
		.line_char       (line_char),
		.char_index      (char_index),
		.last_flag       (last_flag),
		.mismatches      (mismatches),
		.awaited         (awaited),
		.results_checked (results_checked),
		.lines_closed    (lines_closed),
		.long_lines      (long_lines)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver stalls at random, or holds off for a long stretch when asked to.
	initial begin
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] noise_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while ((b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_CR || b == CHAR_LF);
		return b;
	endfunction

	task automatic send_line(input int len, input int noise_pct, input logic [BYTE_W-1:0] term);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_byte(noise_byte());
			send_byte(BYTE_W'($urandom_range(PRINT_LO, PRINT_HI)));
		end
		send_byte(term);
	endtask

	// Short lines with stray non-printable bytes mixed in, with now and then an empty line or a
	// second terminator straight after the first.
	task automatic random_lines(input int budget);
		int                line_items;
		int                len;
		int                pick;
		logic [BYTE_W-1:0] term;
		line_items = 0;
		while (line_items < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				len = 0;
			else
				len = $urandom_range(1, budget - line_items);
			term = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
			send_line(len, 10, term);
			line_items += len + 1;
			if ($urandom_range(0, 9) == 0) begin
				send_byte(term == CHAR_CR ? CHAR_LF : CHAR_CR);
				line_items++;
			end
		end
	endtask

	initial begin
		opening_bytes = '{8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF, CHAR_CR, 8'h20, CHAR_CR,
			8'h7E, 8'h09, 8'h41, 8'hAA, 8'h5A, CHAR_LF, CHAR_LF, 8'h30, 8'h55, CHAR_CR,
			CHAR_LF, 8'h2A, CHAR_LF};
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 17;
		rx_idle_pct = 59;
		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);

		// With the receiver held off, a full line fills the output path and the block has
		// to stall its input while the overlong line that follows is on offer.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests <= hold_requests + 1;
		send_line(LINE_MAX_DEF, 0, CHAR_CR);
		send_line(LINE_MAX_DEF + 1, 0, CHAR_LF);

		tx_idle_pct = 17;
		rx_idle_pct = 59;
		random_lines(PHASE_ITEMS);
		tx_idle_pct = 59;
		rx_idle_pct = 17;
		random_lines(PHASE_ITEMS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_lines(PHASE_ITEMS);

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited != 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d bytes: extreme and ignored bytes, empty, full and overlong lines,",
			bytes_sent);
		$display("random lines under three idle patterns; %0d results in %0d lines, %0d overflows.",
			results_checked, lines_closed, long_lines);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
